@@ rtl/pacr_pkg.sv @@
// Shared types and constants for the polygon area / right corner block.
// No dependencies; imported by every module of the block.
package pacr_pkg;

  // Significant coordinate bits; bits above this in the input fields are ignored.
  localparam int COORD_BITS  = 16;
  localparam int FIELD_BITS  = 16;
  localparam int EDGE_BITS   = COORD_BITS + 1;
  localparam int EPROD_BITS  = 2 * EDGE_BITS;
  localparam int DOT_BITS    = EPROD_BITS + 1;
  localparam int PPROD_BITS  = 2 * COORD_BITS;
  localparam int CROSS_BITS  = PPROD_BITS + 2;
  localparam int SUM_BITS    = 50;
  localparam int AREA_BITS   = 49;
  localparam int COUNT_BITS  = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
  localparam logic [COUNT_BITS-1:0] MIN_VERTICES = COUNT_BITS'(3);
  localparam logic [COUNT_BITS-1:0] SECOND_VTX   = COUNT_BITS'(1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] x_coord;
    logic signed [FIELD_BITS-1:0] y_coord;
    logic                         last_vertex;
  } in_item_t;

  typedef struct packed {
    logic [AREA_BITS-1:0]  double_area;
    logic [COUNT_BITS-1:0] vertex_count;
    logic                  right_corner;
    status_e               status;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [EDGE_BITS-1:0] x;
    logic signed [EDGE_BITS-1:0] y;
  } edge_t;

  // first: opens a polygon; test: corner at previous vertex gets checked;
  // last: closes the polygon; close: wrap-around corners are checked.
  typedef struct packed {
    logic first;
    logic test;
    logic last;
    logic close;
  } work_flags_t;

  typedef struct packed {
    point_t                prev_pt;
    point_t                cur_pt;
    point_t                first_pt;
    edge_t                 cur_edge;
    edge_t                 prev_edge;
    edge_t                 first_edge;
    edge_t                 close_edge;
    work_flags_t           flags;
    logic [COUNT_BITS-1:0] count;
    status_e               status;
  } work_t;

endpackage

@@ rtl/pacr_front.sv @@
// Front end: accepts vertices, tracks polygon position, forms edge vectors.
// Depends on pacr_pkg; pushes one work entry per vertex into pacr_queue.
module pacr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pacr_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output pacr_pkg::work_t   q_data_o
);
  import pacr_pkg::*;

  point_t                first_pt_q, prev_pt_q;
  edge_t                 first_edge_q, prev_edge_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  ovf_q, ovf_d;

  logic                  accept, is_first, is_second, at_max;
  point_t                cur_pt, first_eff;
  edge_t                 cur_edge, close_edge;
  logic [COUNT_BITS-1:0] count_next;
  logic                  ovf_next;
  work_t                 work;

  always_comb begin
    accept     = in_valid_i && !q_full_i;
    cur_pt.x   = in_data_i.x_coord[COORD_BITS-1:0];
    cur_pt.y   = in_data_i.y_coord[COORD_BITS-1:0];
    is_first   = (count_q == '0);
    is_second  = (count_q == SECOND_VTX);
    at_max     = (count_q == COUNT_MAX);
    first_eff  = is_first ? cur_pt : first_pt_q;

    cur_edge.x   = EDGE_BITS'(cur_pt.x) - EDGE_BITS'(prev_pt_q.x);
    cur_edge.y   = EDGE_BITS'(cur_pt.y) - EDGE_BITS'(prev_pt_q.y);
    close_edge.x = EDGE_BITS'(first_eff.x) - EDGE_BITS'(cur_pt.x);
    close_edge.y = EDGE_BITS'(first_eff.y) - EDGE_BITS'(cur_pt.y);

    count_next = at_max ? count_q : count_q + COUNT_BITS'(1);
    ovf_next   = (ovf_q && !is_first) || at_max;

    work.prev_pt     = prev_pt_q;
    work.cur_pt      = cur_pt;
    work.first_pt    = first_eff;
    work.cur_edge    = cur_edge;
    work.prev_edge   = prev_edge_q;
    work.first_edge  = first_edge_q;
    work.close_edge  = close_edge;
    work.flags.first = is_first;
    work.flags.test  = !is_first && !is_second;
    work.flags.last  = in_data_i.last_vertex;
    work.flags.close = (count_next >= MIN_VERTICES);
    work.count       = count_next;
    if (ovf_next) begin
      work.status = STATUS_OVERFLOW;
    end else if (count_next < MIN_VERTICES) begin
      work.status = STATUS_SHORT;
    end else begin
      work.status = STATUS_OK;
    end

    // the final vertex starts a fresh polygon
    count_d = in_data_i.last_vertex ? '0 : count_next;
    ovf_d   = in_data_i.last_vertex ? 1'b0 : ovf_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_pt_q <= first_eff;
      prev_pt_q  <= cur_pt;
      if (!is_first) begin
        prev_edge_q <= cur_edge;
      end
      if (is_second) begin
        first_edge_q <= cur_edge;
      end
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = accept;
  assign q_data_o   = work;

endmodule

@@ rtl/pacr_queue.sv @@
// Short FIFO of work entries between front and back end.
// Depends on pacr_pkg (work_t, QUEUE_DEPTH).
module pacr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pacr_pkg::work_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pacr_pkg::work_t data_o
);
  import pacr_pkg::*;

  work_t                entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] fill_q, fill_d;
  logic                 do_pop;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    logic [QPTR_BITS-1:0] r;
    if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_BITS'(1);
    end
    return r;
  endfunction

  always_comb begin
    do_pop   = pop_i && (fill_q != '0);
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !do_pop) begin
      fill_d = fill_q + QCNT_BITS'(1);
    end else if (!push_i && do_pop) begin
      fill_d = fill_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (fill_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

endmodule

@@ rtl/pacr_back.sv @@
// Back end: products, shoelace accumulation, corner tests, result register.
// Depends on pacr_pkg; pops work entries from pacr_queue.
module pacr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  pacr_pkg::work_t    q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pacr_pkg::out_item_t out_data_o
);
  import pacr_pkg::*;

  logic en;

  // stage 1: products
  logic                         s1_valid_q;
  work_flags_t                  s1_flags_q;
  logic [COUNT_BITS-1:0]        s1_count_q;
  status_e                      s1_status_q;
  logic signed [PPROD_BITS-1:0] cp0_q, cp1_q, cl0_q, cl1_q;
  logic signed [EPROD_BITS-1:0] d0_q, d1_q, d2_q, d3_q, d4_q, d5_q;

  // stage 2: cross sum term and perpendicular tests
  logic                         s2_valid_q;
  work_flags_t                  s2_flags_q;
  logic [COUNT_BITS-1:0]        s2_count_q;
  status_e                      s2_status_q;
  logic signed [CROSS_BITS-1:0] cross_q, cross_d, step_cross, close_cross;
  logic                         perp_step_q, perp_step_d, perp_close_q, perp_close_d;
  logic signed [DOT_BITS-1:0]   dot_step, dot_prev_close, dot_close_first;

  // stage 3: running polygon state and raw result
  logic [SUM_BITS-1:0]   acc_q, acc_d;
  logic                  rs_q, rs_d;
  logic                  res_valid_q;
  logic [SUM_BITS-1:0]   res_sum_q;
  logic                  res_right_q;
  logic [COUNT_BITS-1:0] res_count_q;
  status_e               res_status_q;

  // output register
  logic                  out_valid_q;
  out_item_t             out_data_q, out_data_d;
  logic [SUM_BITS-1:0]   mag;

  assign en      = !out_valid_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_flags_q  <= q_data_i.flags;
      s1_count_q  <= q_data_i.count;
      s1_status_q <= q_data_i.status;
      cp0_q <= PPROD_BITS'(q_data_i.prev_pt.x) * PPROD_BITS'(q_data_i.cur_pt.y);
      cp1_q <= PPROD_BITS'(q_data_i.prev_pt.y) * PPROD_BITS'(q_data_i.cur_pt.x);
      cl0_q <= PPROD_BITS'(q_data_i.cur_pt.x) * PPROD_BITS'(q_data_i.first_pt.y);
      cl1_q <= PPROD_BITS'(q_data_i.cur_pt.y) * PPROD_BITS'(q_data_i.first_pt.x);
      d0_q  <= EPROD_BITS'(q_data_i.prev_edge.x) * EPROD_BITS'(q_data_i.cur_edge.x);
      d1_q  <= EPROD_BITS'(q_data_i.prev_edge.y) * EPROD_BITS'(q_data_i.cur_edge.y);
      // on a closing vertex the latest edge is the current one
      d2_q  <= EPROD_BITS'(q_data_i.cur_edge.x) * EPROD_BITS'(q_data_i.close_edge.x);
      d3_q  <= EPROD_BITS'(q_data_i.cur_edge.y) * EPROD_BITS'(q_data_i.close_edge.y);
      d4_q  <= EPROD_BITS'(q_data_i.close_edge.x) * EPROD_BITS'(q_data_i.first_edge.x);
      d5_q  <= EPROD_BITS'(q_data_i.close_edge.y) * EPROD_BITS'(q_data_i.first_edge.y);
    end
  end

  always_comb begin
    step_cross  = '0;
    close_cross = '0;
    if (!s1_flags_q.first) begin
      step_cross = CROSS_BITS'(cp0_q) - CROSS_BITS'(cp1_q);
    end
    if (s1_flags_q.last) begin
      close_cross = CROSS_BITS'(cl0_q) - CROSS_BITS'(cl1_q);
    end
    cross_d = step_cross + close_cross;

    dot_step        = DOT_BITS'(d0_q) + DOT_BITS'(d1_q);
    dot_prev_close  = DOT_BITS'(d2_q) + DOT_BITS'(d3_q);
    dot_close_first = DOT_BITS'(d4_q) + DOT_BITS'(d5_q);
    perp_step_d  = s1_flags_q.test && (dot_step == '0);
    perp_close_d = s1_flags_q.last && s1_flags_q.close &&
                   ((dot_prev_close == '0) || (dot_close_first == '0));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_flags_q   <= s1_flags_q;
      s2_count_q   <= s1_count_q;
      s2_status_q  <= s1_status_q;
      cross_q      <= cross_d;
      perp_step_q  <= perp_step_d;
      perp_close_q <= perp_close_d;
    end
  end

  always_comb begin
    acc_d = s2_flags_q.first ? '0 : acc_q;
    rs_d  = s2_flags_q.first ? 1'b0 : rs_q;
    acc_d = acc_d + SUM_BITS'(cross_q);
    rs_d  = rs_d || perp_step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      rs_q        <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      res_valid_q <= s2_valid_q && s2_flags_q.last;
      out_valid_q <= res_valid_q;
      if (s2_valid_q) begin
        acc_q <= acc_d;
        rs_q  <= rs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_sum_q    <= acc_d;
      res_right_q  <= s2_flags_q.close && (rs_d || perp_close_q);
      res_count_q  <= s2_count_q;
      res_status_q <= s2_status_q;
      out_data_q   <= out_data_d;
    end
  end

  always_comb begin
    mag = res_sum_q;
    if (res_sum_q[SUM_BITS-1]) begin
      mag = '0 - res_sum_q;
    end
    out_data_d.double_area  = mag[AREA_BITS-1:0];
    out_data_d.vertex_count = res_count_q;
    out_data_d.right_corner = res_right_q;
    out_data_d.status       = res_status_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/polygon_area_right_corner.sv @@
// Top level: shoelace polygon area with right-corner detection.
// Depends on pacr_pkg, pacr_front, pacr_queue and pacr_back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   in      | input     | in_valid_i/in_ready_o | x_coord, y_coord, last_vertex
//   out     | output    | out_valid_o/out_ready_i | double_area, vertex_count,
//           |           |                       | right_corner, status
//
// One vertex per clock sustained while the back end is not frozen; the result
// of the final vertex passes through the queue read, product, sum and
// accumulate stages and then the output register.
// Reset clears all control state at once; there is no clearing pass.
// out_ready_i low with a result held freezes the back end; the two-entry
// queue keeps in_ready_o high until it fills.
module polygon_area_right_corner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pacr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pacr_pkg::out_item_t out_data_o
);
  import pacr_pkg::*;

  logic  q_push, q_full, q_pop, q_valid;
  work_t q_wdata, q_rdata;

  pacr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  pacr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  pacr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/pacr_checker.sv @@
// Port-level checks for polygon_area_right_corner, bound to the top level.
// Depends on pacr_pkg.
module pacr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input pacr_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pacr_pkg::out_item_t out_data_o
);
  import pacr_pkg::*;

  // a waiting vertex transaction holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("vertex changed or dropped while waiting");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_OK) |->
      out_data_o.vertex_count >= MIN_VERTICES)
    else $error("ok status with fewer than three vertices");

  // one or two vertices always give a zero shoelace sum and no corner
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_SHORT) |->
      (out_data_o.double_area == '0) && !out_data_o.right_corner &&
      (out_data_o.vertex_count < MIN_VERTICES))
    else $error("short polygon result inconsistent");

  a_ovf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_OVERFLOW) |->
      out_data_o.vertex_count == COUNT_MAX)
    else $error("overflow status without saturated count");

endmodule

bind polygon_area_right_corner pacr_checker u_pacr_checker (.*);
